// ===== sv/irc_line_tokenizer_unit_assert.svh =====
// ---------------------------------------------------------------------------
// IRC line tokenizer assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off while in reset.
// ---------------------------------------------------------------------------
`ifndef IRC_LINE_TOKENIZER_UNIT_ASSERT_SVH
`define IRC_LINE_TOKENIZER_UNIT_ASSERT_SVH

// property must hold at every edge outside reset
`define IRCLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IRCLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/irc_lt_pkg.sv =====
// ---------------------------------------------------------------------------
// IRC line tokenizer package
// Phase codes, byte roles, item and state types, character helpers.
// ---------------------------------------------------------------------------
package irc_lt_pkg;

  localparam int MaxParams   = 15;
  localparam int ParamCapInt = (MaxParams > 15) ? 15 : ((MaxParams < 1) ? 1 : MaxParams);
  localparam logic [3:0] PARAM_CAP = 4'(ParamCapInt);

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [2:0] ROLE_SEP    = 3'd0;
  localparam logic [2:0] ROLE_PREFIX = 3'd1;
  localparam logic [2:0] ROLE_VERB   = 3'd2;
  localparam logic [2:0] ROLE_MIDDLE = 3'd3;
  localparam logic [2:0] ROLE_TRAIL  = 3'd4;

  typedef enum logic [2:0] {
    PH_START      = 3'd0,
    PH_PREFIX     = 3'd1,
    PH_SKIP_VERB  = 3'd2,
    PH_VERB       = 3'd3,
    PH_SKIP_PARAM = 3'd4,
    PH_MIDDLE     = 3'd5,
    PH_TRAIL      = 3'd6
  } phase_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       byte_valid;
    logic       line_end;
  } item_t;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] param_count;
    logic       overflow_seen;
  } state_t;

  localparam state_t ST_RESET = '{phase: PH_START, param_count: 4'd0, overflow_seen: 1'b0};

  typedef struct packed {
    logic [7:0] out_char;
    logic [2:0] role;
    logic [3:0] param_index;
    logic       token_start;
    logic       line_done;
    logic       line_ok;
    logic       param_overflow;
  } res_t;

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
  endfunction

endpackage

// ===== sv/irc_lt_core.sv =====
// ---------------------------------------------------------------------------
// IRC line tokenizer step logic
// Next tokenizer state and tagged result for one byte item.
// ---------------------------------------------------------------------------
module irc_lt_core (
  input  irc_lt_pkg::item_t  item_i,
  input  irc_lt_pkg::state_t st_i,
  output irc_lt_pkg::state_t st_o,
  output irc_lt_pkg::res_t   res_o
);

  irc_lt_pkg::phase_e ph;
  irc_lt_pkg::state_t st_upd;
  logic               ws;
  logic [3:0]         cur_idx;

  // unused phase code acts as start of line
  assign ph = (st_i.phase > irc_lt_pkg::PH_TRAIL) ? irc_lt_pkg::PH_START : st_i.phase;
  assign ws = irc_lt_pkg::is_ws(item_i.ch);

  // next state
  always_comb begin
    st_upd       = st_i;
    st_upd.phase = ph;
    if (item_i.byte_valid) begin
      case (ph)
        irc_lt_pkg::PH_START: begin
          if (item_i.ch == irc_lt_pkg::CH_COLON) begin
            st_upd.phase = irc_lt_pkg::PH_PREFIX;
          end else if (ws) begin
            st_upd.phase = irc_lt_pkg::PH_SKIP_VERB;
          end else begin
            st_upd.phase = irc_lt_pkg::PH_VERB;
          end
        end
        irc_lt_pkg::PH_PREFIX: begin
          if (item_i.ch == irc_lt_pkg::CH_SPACE) st_upd.phase = irc_lt_pkg::PH_SKIP_VERB;
        end
        irc_lt_pkg::PH_SKIP_VERB: begin
          if (!ws) st_upd.phase = irc_lt_pkg::PH_VERB;
        end
        irc_lt_pkg::PH_VERB: begin
          if (item_i.ch == irc_lt_pkg::CH_SPACE) st_upd.phase = irc_lt_pkg::PH_SKIP_PARAM;
        end
        irc_lt_pkg::PH_SKIP_PARAM: begin
          if (!ws) begin
            if (st_i.param_count < irc_lt_pkg::PARAM_CAP) begin
              st_upd.param_count = st_i.param_count + 4'd1;
            end else begin
              st_upd.overflow_seen = 1'b1;
            end
            st_upd.phase = (item_i.ch == irc_lt_pkg::CH_COLON) ?
                           irc_lt_pkg::PH_TRAIL : irc_lt_pkg::PH_MIDDLE;
          end
        end
        irc_lt_pkg::PH_MIDDLE: begin
          if (item_i.ch == irc_lt_pkg::CH_SPACE) st_upd.phase = irc_lt_pkg::PH_SKIP_PARAM;
        end
        default: begin
          st_upd.phase = ph;
        end
      endcase
    end
  end

  assign st_o    = item_i.line_end ? irc_lt_pkg::ST_RESET : st_upd;
  assign cur_idx = (st_upd.param_count == 4'd0) ? 4'd0 : (st_upd.param_count - 4'd1);

  // result
  always_comb begin
    res_o                = '0;
    res_o.line_done      = item_i.line_end;
    res_o.line_ok        = item_i.line_end && (st_upd.phase >= irc_lt_pkg::PH_VERB);
    res_o.param_overflow = st_upd.overflow_seen;
    if (item_i.byte_valid) begin
      res_o.out_char = item_i.ch;
      case (ph)
        irc_lt_pkg::PH_START: begin
          if (item_i.ch == irc_lt_pkg::CH_COLON) begin
            res_o.role = irc_lt_pkg::ROLE_PREFIX;
          end else if (!ws) begin
            res_o.role        = irc_lt_pkg::ROLE_VERB;
            res_o.token_start = 1'b1;
            res_o.out_char    = irc_lt_pkg::to_upper(item_i.ch);
          end
        end
        irc_lt_pkg::PH_PREFIX: begin
          if (item_i.ch != irc_lt_pkg::CH_SPACE) res_o.role = irc_lt_pkg::ROLE_PREFIX;
        end
        irc_lt_pkg::PH_SKIP_VERB: begin
          if (!ws) begin
            res_o.role        = irc_lt_pkg::ROLE_VERB;
            res_o.token_start = 1'b1;
            res_o.out_char    = irc_lt_pkg::to_upper(item_i.ch);
          end
        end
        irc_lt_pkg::PH_VERB: begin
          if (item_i.ch != irc_lt_pkg::CH_SPACE) begin
            res_o.role     = irc_lt_pkg::ROLE_VERB;
            res_o.out_char = irc_lt_pkg::to_upper(item_i.ch);
          end
        end
        irc_lt_pkg::PH_SKIP_PARAM: begin
          if (!ws) begin
            res_o.token_start = 1'b1;
            res_o.param_index = cur_idx;
            res_o.role        = (item_i.ch == irc_lt_pkg::CH_COLON) ?
                                irc_lt_pkg::ROLE_TRAIL : irc_lt_pkg::ROLE_MIDDLE;
          end
        end
        irc_lt_pkg::PH_MIDDLE: begin
          if (item_i.ch != irc_lt_pkg::CH_SPACE) begin
            res_o.role        = irc_lt_pkg::ROLE_MIDDLE;
            res_o.param_index = cur_idx;
          end
        end
        default: begin
          res_o.role        = irc_lt_pkg::ROLE_TRAIL;
          res_o.param_index = cur_idx;
        end
      endcase
    end
  end

endmodule

// ===== sv/irc_line_tokenizer_unit.sv =====
// ---------------------------------------------------------------------------
// IRC line tokenizer
// Tags each byte of a command line as prefix, verb, parameter or separator.
// ---------------------------------------------------------------------------
// Takes one byte item per cycle when not stalled and returns one tagged item
// per byte through input register, then result register. Throughput is one
// item per clock when not stalled, bounded by the update of the tokenizer
// phase and parameter count. While a result waits on the output, the input
// register takes one more item and the input then stalls until the waiting
// result is taken. A bare item (tuser low) carries only the end-of-line
// mark. The result with tlast high reports line_ok and the line's overflow
// flag, and the tokenizer returns to start of line for the next item.
module irc_line_tokenizer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] ch
  input  logic       s_axis_tuser,   // [0] byte_valid
  input  logic       s_axis_tlast,   // line_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic [9:0] m_axis_tuser,   // [2:0] role, [6:3] param_index, [7] token_start,
                                     // [8] line_ok, [9] param_overflow
  output logic       m_axis_tlast    // line_done
);

  irc_lt_pkg::item_t  in_q;
  logic               in_vld_q, in_vld_d;
  irc_lt_pkg::state_t st_q, st_d;
  irc_lt_pkg::res_t   res_q, res_d;
  logic               out_vld_q, out_vld_d;
  logic               s_acc, advance;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign in_vld_d  = s_acc ? 1'b1 : (advance ? 1'b0 : in_vld_q);
  assign out_vld_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);

  irc_lt_core u_core (
    .item_i (in_q),
    .st_i   (st_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= irc_lt_pkg::ST_RESET;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_q <= '{ch: s_axis_tdata, byte_valid: s_axis_tuser, line_end: s_axis_tlast};
    end
    if (advance) res_q <= res_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q.out_char;
  assign m_axis_tuser  = {res_q.param_overflow, res_q.line_ok, res_q.token_start,
                          res_q.param_index, res_q.role};
  assign m_axis_tlast  = res_q.line_done;

endmodule

// ===== sv/irc_lt_checker.sv =====
// ---------------------------------------------------------------------------
// IRC line tokenizer port checker
// Result stream consistency checks, bound to the tokenizer top level.
// ---------------------------------------------------------------------------
`include "irc_line_tokenizer_unit_assert.svh"

module irc_lt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [9:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  logic [2:0] role;
  assign role = m_axis_tuser[2:0];

  `IRCLT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

  // success is only reported on the line's last item
  `IRCLT_ASSERT(a_ok_at_end, !(m_axis_tvalid && m_axis_tuser[8]) || m_axis_tlast, "line_ok without line_done")

  `IRCLT_ASSERT(a_start_role, !(m_axis_tvalid && m_axis_tuser[7]) || role == irc_lt_pkg::ROLE_VERB || role == irc_lt_pkg::ROLE_MIDDLE || role == irc_lt_pkg::ROLE_TRAIL, "token start outside a token")

  // nonzero index only inside parameters
  `IRCLT_ASSERT(a_index_role, !(m_axis_tvalid && m_axis_tuser[6:3] != 4'd0) || role == irc_lt_pkg::ROLE_MIDDLE || role == irc_lt_pkg::ROLE_TRAIL, "parameter index outside a parameter")

endmodule

bind irc_line_tokenizer_unit irc_lt_checker u_irc_lt_checker (.*);

// ===== tb/irc_line_tag_checker.sv =====
// ---------------------------------------------------------------------------
// IRC line tag checker
// Watches both streams of the line tokenizer, predicts the tag of every
// accepted byte item and compares each result item field by field.
// ---------------------------------------------------------------------------
module irc_line_tag_checker
  import irc_lt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_char_i,
  input  logic       in_byte_valid_i,
  input  logic       in_line_end_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_char_i,
  input  logic [9:0] out_tags_i,      // [2:0] role, [6:3] param_index, [7] token_start,
                                      // [8] line_ok, [9] param_overflow
  input  logic       out_line_done_i,
  output int         errors_o,
  output int         pending_o
);

  // tokenizer state as seen by the prediction
  phase_e     tok_phase;
  logic [3:0] tok_params;
  logic       tok_ovf;

  res_t  tag_expect_q[$];
  res_t  exp_r;
  res_t  got_r;
  item_t in_r;
  int    err_cnt = 0;

  function automatic logic blank_byte(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ? {c[7:6], 1'b0, c[4:0]} : c;
  endfunction

  function automatic logic [3:0] param_slot(logic [3:0] n);
    return (n == 4'd0) ? 4'd0 : n - 4'd1;
  endfunction

  task automatic clear_line();
    tok_phase  = PH_START;
    tok_params = 4'd0;
    tok_ovf    = 1'b0;
  endtask

  task automatic tag_byte(input item_t it, output res_t r);
    logic [7:0] c;
    c = it.ch;
    r = '0;
    if (it.byte_valid) begin
      r.out_char = c;
      case (tok_phase)
        PH_START: begin
          if (c == CH_COLON) begin
            r.role    = ROLE_PREFIX;
            tok_phase = PH_PREFIX;
          end else if (blank_byte(c)) begin
            tok_phase = PH_SKIP_VERB;
          end else begin
            r.role        = ROLE_VERB;
            r.token_start = 1'b1;
            r.out_char    = fold_case(c);
            tok_phase     = PH_VERB;
          end
        end
        PH_PREFIX: begin
          if (c == CH_SPACE) tok_phase = PH_SKIP_VERB;
          else r.role = ROLE_PREFIX;
        end
        PH_SKIP_VERB: begin
          if (!blank_byte(c)) begin
            r.role        = ROLE_VERB;
            r.token_start = 1'b1;
            r.out_char    = fold_case(c);
            tok_phase     = PH_VERB;
          end
        end
        PH_VERB: begin
          if (c == CH_SPACE) begin
            tok_phase = PH_SKIP_PARAM;
          end else begin
            r.role     = ROLE_VERB;
            r.out_char = fold_case(c);
          end
        end
        PH_SKIP_PARAM: begin
          if (!blank_byte(c)) begin
            // count saturates at the cap; later params share the last index
            if (tok_params < PARAM_CAP) tok_params = tok_params + 4'd1;
            else tok_ovf = 1'b1;
            r.token_start = 1'b1;
            r.param_index = param_slot(tok_params);
            if (c == CH_COLON) begin
              r.role    = ROLE_TRAIL;
              tok_phase = PH_TRAIL;
            end else begin
              r.role    = ROLE_MIDDLE;
              tok_phase = PH_MIDDLE;
            end
          end
        end
        PH_MIDDLE: begin
          if (c == CH_SPACE) begin
            tok_phase = PH_SKIP_PARAM;
          end else begin
            r.role        = ROLE_MIDDLE;
            r.param_index = param_slot(tok_params);
          end
        end
        default: begin
          r.role        = ROLE_TRAIL;
          r.param_index = param_slot(tok_params);
        end
      endcase
    end
    r.param_overflow = tok_ovf;
    if (it.line_end) begin
      r.line_done = 1'b1;
      r.line_ok   = (tok_phase >= PH_VERB);
      clear_line();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_line();
      tag_expect_q.delete();
      pending_o <= 0;
      errors_o  <= err_cnt;
    end else begin
      if (in_valid_i && in_ready_i) begin
        in_r.ch         = in_char_i;
        in_r.byte_valid = in_byte_valid_i;
        in_r.line_end   = in_line_end_i;
        tag_byte(in_r, exp_r);
        tag_expect_q.push_back(exp_r);
      end
      if (out_valid_i && out_ready_i) begin
        got_r.out_char       = out_char_i;
        got_r.role           = out_tags_i[2:0];
        got_r.param_index    = out_tags_i[6:3];
        got_r.token_start    = out_tags_i[7];
        got_r.line_ok        = out_tags_i[8];
        got_r.param_overflow = out_tags_i[9];
        got_r.line_done      = out_line_done_i;
        if (tag_expect_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result item: char=%h role=%0d idx=%0d ts=%b done=%b ok=%b ovf=%b",
                     got_r.out_char, got_r.role, got_r.param_index, got_r.token_start,
                     got_r.line_done, got_r.line_ok, got_r.param_overflow);
        end else begin
          exp_r = tag_expect_q.pop_front();
          if ((got_r.out_char !== exp_r.out_char) || (got_r.role !== exp_r.role) ||
              (got_r.param_index !== exp_r.param_index) ||
              (got_r.token_start !== exp_r.token_start) ||
              (got_r.line_done !== exp_r.line_done) || (got_r.line_ok !== exp_r.line_ok) ||
              (got_r.param_overflow !== exp_r.param_overflow)) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("tag mismatch at %0t", $realtime);
              $display("  exp: char=%h role=%0d idx=%0d ts=%b done=%b ok=%b ovf=%b",
                       exp_r.out_char, exp_r.role, exp_r.param_index, exp_r.token_start,
                       exp_r.line_done, exp_r.line_ok, exp_r.param_overflow);
              $display("  got: char=%h role=%0d idx=%0d ts=%b done=%b ok=%b ovf=%b",
                       got_r.out_char, got_r.role, got_r.param_index, got_r.token_start,
                       got_r.line_done, got_r.line_ok, got_r.param_overflow);
            end
          end
        end
      end
      pending_o <= tag_expect_q.size();
      errors_o  <= err_cnt;
    end
  end

endmodule

// ===== tb/tb_irc_line_tokenizer_unit.sv =====
// ---------------------------------------------------------------------------
// IRC line tokenizer testbench
// Feeds directed and random command lines byte by byte with random gaps and
// output stalls; a separate checker predicts and compares every result item.
// ---------------------------------------------------------------------------
module tb_irc_line_tokenizer_unit;
  import irc_lt_pkg::*;

  localparam int BytesTotal    = 1250;
  localparam int QuietFrom     = 1050;
  localparam int StallAt       = 400;
  localparam int StallCycles   = 80;
  localparam int WatchdogLimit = 1000;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tuser;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [9:0] m_axis_tuser;
  logic       m_axis_tlast;

  int    errors;
  int    pending;
  int    bytes_sent = 0;
  int    idle_cycles = 0;
  bit    quiet = 1'b0;
  bit    tx_idle_on = 1'b0;
  item_t line_q[$];

  irc_line_tokenizer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  irc_line_tag_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_i      (s_axis_tready),
    .in_char_i       (s_axis_tdata),
    .in_byte_valid_i (s_axis_tuser),
    .in_line_end_i   (s_axis_tlast),
    .out_valid_i     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_char_i      (m_axis_tdata),
    .out_tags_i      (m_axis_tuser),
    .out_line_done_i (m_axis_tlast),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // no-progress watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("irc_line_tokenizer_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // output side: random stall bursts, one long hold-off to back up the block
  initial begin
    int  stall_left;
    int  span;
    bit  rx_idle_on;
    bit  pressure_done;
    stall_left    = 0;
    span          = 0;
    rx_idle_on    = 1'b1;
    pressure_done = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        span       = 64;
        rx_idle_on = ($urandom_range(0, 2) != 0);
      end
      span--;
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else if (!pressure_done && bytes_sent >= StallAt) begin
        pressure_done = 1'b1;
        stall_left    = StallCycles - 1;
        m_axis_tready = 1'b0;
      end else if (!quiet && rx_idle_on && $urandom_range(0, 9) == 0) begin
        stall_left    = $urandom_range(0, 16);
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_item(input item_t it);
    int gap;
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = it.ch;
    s_axis_tuser  = it.byte_valid;
    s_axis_tlast  = it.line_end;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic add_item(input logic [7:0] c, input logic v, input logic e);
    item_t it;
    it.ch         = c;
    it.byte_valid = v;
    it.line_end   = e;
    line_q.push_back(it);
  endtask

  // random lines get an occasional bare item in between
  task automatic add_byte(input logic [7:0] c);
    if ($urandom_range(0, 23) == 0) add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    add_item(c, 1'b1, 1'b0);
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) add_item(s[i], 1'b1, 1'b0);
  endtask

  task automatic mark_last();
    int n;
    n = line_q.size() - 1;
    line_q[n].line_end = 1'b1;
  endtask

  task automatic close_line();
    int n;
    n = line_q.size() - 1;
    if (n >= 0 && line_q[n].byte_valid && $urandom_range(0, 1) == 1)
      line_q[n].line_end = 1'b1;
    else
      add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic flush_line();
    quiet      = (bytes_sent >= QuietFrom);
    tx_idle_on = !quiet && ($urandom_range(0, 3) != 0);
    foreach (line_q[i]) send_item(line_q[i]);
    line_q.delete();
  endtask

  function automatic logic [7:0] pick_ws();
    int r;
    r = $urandom_range(8, 13);
    return (r == 8) ? CH_SPACE : 8'(r);
  endfunction

  // token byte: never a space; a first byte also no other whitespace, no colon
  function automatic logic [7:0] pick_word_byte(input bit first);
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 1) == 1) b = 8'h61 + 8'($urandom_range(0, 25));
      else b = 8'($urandom_range(0, 255));
    end while ((b == CH_SPACE) ||
               (first && ((b == CH_COLON) || ((b >= 8'd9) && (b <= 8'd13)))));
    return b;
  endfunction

  task automatic gen_line();
    int np;
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 2) == 0) begin
        add_byte(CH_COLON);
        repeat ($urandom_range(0, 4)) add_byte(pick_word_byte(1'b0));
        add_byte(CH_SPACE);
      end
      repeat ($urandom_range(0, 2)) add_byte(pick_ws());
      add_byte(pick_word_byte(1'b1));
      repeat ($urandom_range(0, 4)) add_byte(pick_word_byte(1'b0));
      // now and then a param count around the cap, 13 to 18
      np = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 18) : $urandom_range(0, 4);
      for (int i = 0; i < np; i++) begin
        add_byte(CH_SPACE);
        repeat ($urandom_range(0, 1)) add_byte(pick_ws());
        if (i == np - 1 && $urandom_range(0, 1) == 1) begin
          add_byte(CH_COLON);
          repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(0, 255)));
        end else begin
          add_byte(pick_word_byte(1'b1));
          repeat ($urandom_range(0, 3)) add_byte(pick_word_byte(1'b0));
        end
      end
      if ($urandom_range(0, 5) == 0) add_byte(CH_SPACE);
    end else begin
      repeat ($urandom_range(0, 10)) begin
        case ($urandom_range(0, 9))
          0, 1:    add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
          2, 3:    add_byte(CH_SPACE);
          4:       add_byte(CH_COLON);
          default: add_byte(8'($urandom_range(0, 255)));
        endcase
      end
    end
    close_line();
    flush_line();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty line: only a bare end marker
    add_item(8'hA5, 1'b0, 1'b1);
    flush_line();
    // prefix that never reaches a space
    add_text(":a");
    mark_last();
    flush_line();
    // whitespace only, both ends of the control range
    add_item(8'h0D, 1'b1, 1'b0);
    add_item(8'h09, 1'b1, 1'b1);
    flush_line();
    // prefix with a tab inside, case folding edges, colon inside the trailing, bare items
    add_text(":n\t `az{ m  :");
    add_item(8'h5A, 1'b0, 1'b0);
    add_item(CH_COLON, 1'b1, 1'b0);
    add_item(8'hFF, 1'b0, 1'b1);
    flush_line();
    // byte extremes as a verb
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hFF, 1'b1, 1'b1);
    flush_line();
    // just outside the whitespace range
    add_item(8'h0E, 1'b1, 1'b0);
    add_item(CH_SPACE, 1'b1, 1'b0);
    add_item(8'h08, 1'b1, 1'b1);
    flush_line();

    while (bytes_sent < BytesTotal) gen_line();
    s_axis_tvalid = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending == 0)
      $display("irc_line_tokenizer_unit verification clean");
    else
      $display("irc_line_tokenizer_unit verification failed");
    $finish;
  end

endmodule
